// ===== sv/sorted_insert_priority_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted insert priority list
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_LIST_TOP_MACROS_SVH
`define SORTED_INSERT_PRIORITY_LIST_TOP_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define SIPL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define SIPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sipl_pkg.sv =====
// ----------------------------------------------------------------------------
// sipl_pkg
// Types, codes and helpers shared by the sorted insert priority list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sipl_pkg;

   // Number of entries the list can hold.
   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // Command codes.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_OFFER = 2'd1;
   localparam logic [1:0] CMD_POP   = 2'd2;

   // Result status codes.
   localparam logic [2:0] STS_CLEARED = 3'd0;
   localparam logic [2:0] STS_STORED  = 3'd1;
   localparam logic [2:0] STS_IGNORED = 3'd2;
   localparam logic [2:0] STS_DROPPED = 3'd3;
   localparam logic [2:0] STS_POPPED  = 3'd4;
   localparam logic [2:0] STS_EMPTY   = 3'd5;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] offer_key;
      logic               eligible;
      logic [15:0]        offer_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] best_key;
      logic [15:0]        best_tag;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [15:0]        tag;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_PLACE,
      ST_POP_WAIT,
      ST_RESP
   } state_type;

   // Physical slot of a logical list position in the circular store.
   function automatic idx_type phys_addr(input idx_type head, input idx_type pos);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (IDX_W+1)'(LIST_DEPTH)) begin
         sum = sum - (IDX_W+1)'(LIST_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/sipl_ram.sv =====
// ----------------------------------------------------------------------------
// sipl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sipl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/sorted_insert_priority_list_top.sv =====
// ----------------------------------------------------------------------------
// Sorted insert priority list
// Bounded list of keyed entries kept in descending key order, with clear,
// offer (sorted insert) and pop (remove head) commands.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake               Beat contents
//   req_      in    req_valid / req_stall   cmd, offer_key, eligible, offer_tag
//   rsp_      out   rsp_valid / rsp_stall   status, best_key, best_tag, entry_count
//
// Clear, ignored offers, dropped offers and pops of an empty list go from
// accept straight to ST_RESP; a pop passes through ST_POP_WAIT for the head
// entry read. A stored offer to a non-empty list passes ST_INS_CMP, where the
// single compare unit walks the RAM from the tail one entry per cycle, then ST_PLACE.
// Reset is synchronous and empties the list; the entry RAM needs no clearing.
// req_stall is high while a command is in progress; a finished result waits
// in the output register while the next request beat is already accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insert_priority_list_top_macros.svh"

module sorted_insert_priority_list_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sipl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sipl_pkg::rsp_type rsp_data
);

   import sipl_pkg::*;

   // Control state.
   state_type state_ff, state_in;
   idx_type   head_ff, head_in;     // physical slot of the highest entry
   cnt_type   count_ff, count_in;   // entries held
   idx_type   pos_ff, pos_in;       // logical position under compare or to fill
   logic      rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic signed [31:0] key_ff, key_in;
   logic [15:0]        tag_ff, tag_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Entry RAM port signals.
   logic      ram_wr_en;
   idx_type   ram_wr_addr;
   entry_type ram_wr_data;
   idx_type   ram_rd_addr;
   entry_type ram_rd_data;

   logic req_accept;
   logic out_free;
   logic key_above;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // The shared compare unit: does the offered key beat the stored entry?
   assign key_above = (key_ff > ram_rd_data.key);

   sipl_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(LIST_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               priority if (req_data.cmd == CMD_OFFER && req_data.eligible &&
                            count_ff != CNT_W'(LIST_DEPTH)) begin
                  state_in = (count_ff == '0) ? ST_PLACE : ST_INS_CMP;
               end else if (req_data.cmd == CMD_POP && count_ff != '0) begin
                  state_in = ST_POP_WAIT;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_INS_CMP: begin
            if (!key_above || pos_ff == '0) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE:    state_in = ST_RESP;
         ST_POP_WAIT: state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM controls and result formation.
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      tag_in       = tag_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      ram_rd_addr  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in = req_data.offer_key;
               tag_in = req_data.offer_tag;
               res_in = '{status: STS_IGNORED, best_key: '0, best_tag: '0,
                          entry_count: 5'(count_ff)};
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     res_in   = '{status: STS_CLEARED, best_key: '0, best_tag: '0,
                                  entry_count: 5'd0};
                  end
                  CMD_OFFER: begin
                     if (req_data.eligible) begin
                        if (count_ff == CNT_W'(LIST_DEPTH)) begin
                           res_in.status = STS_DROPPED;
                        end else begin
                           // Start the walk at the tail entry.
                           pos_in      = (count_ff == '0) ? '0 : IDX_W'(count_ff - 1'b1);
                           ram_rd_addr = phys_addr(head_ff, IDX_W'(count_ff - 1'b1));
                        end
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STS_EMPTY;
                     end
                  end
                  default: begin
                     res_in.status = STS_IGNORED;
                  end
               endcase
            end
         end
         ST_INS_CMP: begin
            if (key_above) begin
               // Move the smaller entry one place toward the tail.
               ram_wr_en   = 1'b1;
               ram_wr_addr = phys_addr(head_ff, IDX_W'(pos_ff + 1'b1));
               ram_wr_data = ram_rd_data;
               if (pos_ff != '0) begin
                  pos_in      = IDX_W'(pos_ff - 1'b1);
                  ram_rd_addr = phys_addr(head_ff, IDX_W'(pos_ff - 1'b1));
               end
            end else begin
               pos_in = IDX_W'(pos_ff + 1'b1);
            end
         end
         ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = phys_addr(head_ff, pos_ff);
            ram_wr_data = '{key: key_ff, tag: tag_ff};
            count_in    = CNT_W'(count_ff + 1'b1);
            res_in      = '{status: STS_STORED, best_key: '0, best_tag: '0,
                            entry_count: 5'(count_ff + 1'b1)};
         end
         ST_POP_WAIT: begin
            head_in  = phys_addr(head_ff, IDX_W'(1));
            count_in = CNT_W'(count_ff - 1'b1);
            res_in   = '{status: STS_POPPED, best_key: ram_rd_data.key,
                         best_tag: ram_rd_data.tag, entry_count: 5'(count_ff - 1'b1)};
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      tag_ff      <= tag_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted request beat always holds off the next one, with req_stall high after it.
   `SIPL_ASSERT_NEXT(a_accept_then_busy, clock, reset, req_accept, req_stall,
                     "request accepted while busy")

   // The compare walk never points past the held entries.
   `SIPL_ASSERT_NOW(a_walk_in_range, clock, reset, state_ff == ST_INS_CMP,
                    CNT_W'(pos_ff) < count_ff, "insert walk out of range")

   // A pop removes exactly one entry.
   `SIPL_ASSERT_NEXT(a_pop_count, clock, reset, state_ff == ST_POP_WAIT,
                     count_ff == CNT_W'($past(count_ff) - 1'b1), "pop count mismatch")

   // A finished result reaches the output register once it is free.
   `SIPL_ASSERT_NEXT(a_result_loaded, clock, reset, state_ff == ST_RESP && out_free,
                     rsp_valid_ff && rsp_data_ff == $past(res_ff), "result not loaded")

endmodule

`default_nettype wire
